@@ design/vbd_pkg.sv @@
// shared types and constants of the viterbi best path decoder
package vbd_pkg;

   // fixed field formats
   localparam int SCORE_BITS = 16;
   localparam int STATE_BITS = 5;
   localparam int TIME_BITS  = 6;
   localparam int NS_BITS    = 6;

   // default sizes
   localparam int DEF_MAX_STATES = 32;
   localparam int DEF_MAX_FRAMES = 64;
   localparam int DEF_ACC_BITS   = 24;

   // register map
   localparam logic CSR_NUM_STATES = 1'b0;
   localparam logic [NS_BITS-1:0] NUM_STATES_RESET = 6'd32;

   // input word
   typedef struct packed {
      logic                         mode;
      logic [STATE_BITS-1:0]        to_state;
      logic [STATE_BITS-1:0]        from_state;
      logic signed [SCORE_BITS-1:0] score;
      logic                         end_of_sequence;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [TIME_BITS-1:0]  time_index;
      logic [STATE_BITS-1:0] best_state;
      logic                  last;
      logic                  overflow;
   } rsp_word_type;

   // classification done by the front end
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_EMIT,
      KIND_DROP
   } item_kind_type;

   // queued word between front and back
   typedef struct packed {
      item_kind_type                kind;
      logic [STATE_BITS-1:0]        to_state;
      logic [STATE_BITS-1:0]        from_state;
      logic signed [SCORE_BITS-1:0] score;
      logic                         eos;
   } item_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SCAN_END,
      ST_COMMIT,
      ST_EMIT,
      ST_TB_WAIT
   } back_state_type;

endpackage

@@ design/viterbi_best_path_decoder.sv @@
// Viterbi best path decoder, top level with the configuration register.
// Each accepted word is handled one at a time by the back end after it leaves
// a two entry queue. In the back end a transition load or a dropped word
// passes through the idle and decode states. An emission word of the first
// frame, or one past the frame limit, passes through idle, decode and commit.
// A later emission word runs a scan over num_states states and a scan end
// state between decode and commit; the scan reads one previous path score and
// one transition score per cycle, each memory having a single read port. The
// word that carries end_of_sequence then runs the final argmax scan, puts out
// the last frame's element and then reads its back pointer. While a traceback
// is pending, every accepted word, whatever it holds, puts out the next
// element (last frame first) and reads its back pointer, but for the frame 0
// element, which needs no read. Putting out an element waits while the result
// register is still full. No clearing pass is needed after reset.
module viterbi_best_path_decoder
   import vbd_pkg::*;
#(
   parameter int MAX_STATES = DEF_MAX_STATES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int ACC_BITS   = DEF_ACC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_word_type  req_word,
   output logic          empty,
   input  logic          pop,
   output rsp_word_type  rsp_word,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int NSW = $clog2(MAX_STATES + 1);

   logic [NS_BITS-1:0] num_states_ff, num_states_in;
   logic [NSW-1:0]     ns;
   logic               q_valid, q_pop;
   item_type           q_item;

   // configuration register
   always_comb begin
      num_states_in = num_states_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_NUM_STATES)) begin
         num_states_in = pwdata[NS_BITS-1:0];
      end
      prdata = (paddr[2] == CSR_NUM_STATES) ? {26'd0, num_states_ff} : 32'd0;
      pready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= NUM_STATES_RESET;
      end else begin
         num_states_ff <= num_states_in;
      end
   end

   // states in use, zero read as one and clipped at the maximum
   always_comb begin
      if (num_states_ff == '0) begin
         ns = NSW'(1);
      end else if (32'(num_states_ff) > MAX_STATES) begin
         ns = NSW'(MAX_STATES);
      end else begin
         ns = NSW'(num_states_ff);
      end
   end

   vbd_front #(.MAX_STATES(MAX_STATES)) u_front (
      .clock(clock), .reset(reset), .ns(ns),
      .push(push), .full(full), .req_word(req_word),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   vbd_back #(
      .MAX_STATES(MAX_STATES), .MAX_FRAMES(MAX_FRAMES), .ACC_BITS(ACC_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .ns(ns),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .empty(empty), .rsp_word(rsp_word), .pop(pop)
   );

endmodule

@@ design/vbd_ram.sv @@
// generic single write port, single read port ram with registered read
module vbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/vbd_front.sv @@
// front end: accepts words, classifies them and queues them for the back end
module vbd_front
   import vbd_pkg::*;
#(
   parameter int MAX_STATES = DEF_MAX_STATES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_STATES+1)-1:0]  ns,
   input  logic                             push,
   output logic                             full,
   input  req_word_type                     req_word,
   output logic                             q_valid,
   output item_type                         q_item,
   input  logic                             q_pop
);

   item_type   entry_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   logic       to_ok, from_ok, emit_ok;

   // classify the incoming word
   always_comb begin
      to_ok   = 32'(req_word.to_state) < MAX_STATES;
      from_ok = 32'(req_word.from_state) < MAX_STATES;
      emit_ok = 32'(req_word.to_state) < 32'(ns);
      entry_in.to_state   = req_word.to_state;
      entry_in.from_state = req_word.from_state;
      entry_in.score      = req_word.score;
      entry_in.eos        = req_word.end_of_sequence;
      if (req_word.mode == 1'b0) begin
         entry_in.kind = (to_ok && from_ok) ? KIND_LOAD : KIND_DROP;
      end else begin
         entry_in.kind = emit_ok ? KIND_EMIT : KIND_DROP;
      end
   end

   // two entry queue pointers
   always_comb begin
      full      = (count_ff == 2'd2);
      q_valid   = (count_ff != 2'd0);
      q_item    = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = q_pop && q_valid;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ design/vbd_back.sv @@
// back end: score recursion, argmax, traceback and result register
module vbd_back
   import vbd_pkg::*;
#(
   parameter int MAX_STATES = DEF_MAX_STATES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int ACC_BITS   = DEF_ACC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_STATES+1)-1:0]  ns,
   input  logic                             q_valid,
   input  item_type                         q_item,
   output logic                             q_pop,
   output logic                             empty,
   output rsp_word_type                     rsp_word,
   input  logic                             pop
);

   localparam int STW = $clog2(MAX_STATES);
   localparam int FCW = $clog2(MAX_FRAMES + 1);
   localparam int FIW = $clog2(MAX_FRAMES);
   localparam int TR_AW = 2 * STW;
   localparam int PS_AW = STW + 1;
   localparam int BP_AW = FIW + STW;

   function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                   input logic [SCORE_BITS-1:0] b);
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} + {{(ACC_BITS + 1 - SCORE_BITS){b[SCORE_BITS-1]}}, b};
      if (s[ACC_BITS] != s[ACC_BITS-1]) begin
         sat_add = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
         sat_add = s[ACC_BITS-1:0];
      end
   endfunction

   back_state_type       state_ff, state_in;
   item_type             item_ff, item_in;
   logic [FCW-1:0]       fc_ff, fc_in;
   logic                 bank_ff, bank_in;
   logic                 ovf_ff, ovf_in;
   logic                 tb_active_ff, tb_active_in;
   logic [FIW-1:0]       tb_time_ff, tb_time_in;
   logic [STW-1:0]       tb_state_ff, tb_state_in;
   logic                 tb_ovf_ff, tb_ovf_in;
   logic [STW-1:0]       n_ff, n_in;
   logic                 rv_ff, rv_in;
   logic [STW-1:0]       rn_ff, rn_in;
   logic [ACC_BITS-1:0]  best_ff, best_in;
   logic [STW-1:0]       best_n_ff, best_n_in;
   logic                 scan_arg_ff, scan_arg_in;
   logic                 scan_bank_ff, scan_bank_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_word_type         out_ff, out_in;

   logic                 tr_we, ps_we, bp_we;
   logic [TR_AW-1:0]     tr_wa, tr_ra;
   logic [PS_AW-1:0]     ps_wa, ps_ra;
   logic [BP_AW-1:0]     bp_wa, bp_ra;
   logic [SCORE_BITS-1:0] tr_rd;
   logic [ACC_BITS-1:0]  ps_wd, ps_rd;
   logic [STW-1:0]       bp_rd;
   logic [ACC_BITS-1:0]  cand;
   logic                 take;
   logic [STW-1:0]       m_idx;
   logic                 fc_ok, close;
   logic [FCW-1:0]       fc_a;
   logic                 bank_a, ovf_a, out_load;

   // transition scores, path scores and back pointers
   vbd_ram #(.WIDTH(SCORE_BITS), .DEPTH(1 << TR_AW)) u_tr_ram (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(item_ff.score),
      .rd_addr(tr_ra), .rd_data(tr_rd)
   );

   vbd_ram #(.WIDTH(ACC_BITS), .DEPTH(1 << PS_AW)) u_ps_ram (
      .clock(clock), .wr_en(ps_we), .wr_addr(ps_wa), .wr_data(ps_wd),
      .rd_addr(ps_ra), .rd_data(ps_rd)
   );

   vbd_ram #(.WIDTH(STW), .DEPTH(1 << BP_AW)) u_bp_ram (
      .clock(clock), .wr_en(bp_we), .wr_addr(bp_wa), .wr_data(best_n_ff),
      .rd_addr(bp_ra), .rd_data(bp_rd)
   );

   // running max over the scanned states, lower index wins ties
   always_comb begin
      cand = scan_arg_ff ? ps_rd : sat_add(ps_rd, tr_rd);
      take = rv_ff && ((rn_ff == '0) || ($signed(cand) > $signed(best_ff)));
      best_in   = take ? cand : best_ff;
      best_n_in = take ? rn_ff : best_n_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      fc_in        = fc_ff;
      bank_in      = bank_ff;
      ovf_in       = ovf_ff;
      tb_active_in = tb_active_ff;
      tb_time_in   = tb_time_ff;
      tb_state_in  = tb_state_ff;
      tb_ovf_in    = tb_ovf_ff;
      n_in         = n_ff;
      rv_in        = 1'b0;
      rn_in        = n_ff;
      scan_arg_in  = scan_arg_ff;
      scan_bank_in = scan_bank_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      out_load     = 1'b0;
      q_pop        = 1'b0;

      m_idx = STW'(item_ff.to_state);
      fc_ok = 32'(fc_ff) < MAX_FRAMES;
      close = (32'(item_ff.to_state) == 32'(ns) - 1) || item_ff.eos;
      fc_a   = fc_ff;
      bank_a = bank_ff;
      ovf_a  = ovf_ff | !fc_ok;
      if (fc_ok && close) begin
         fc_a   = fc_ff + FCW'(1);
         bank_a = !bank_ff;
      end

      tr_we = 1'b0;
      tr_wa = {STW'(item_ff.to_state), STW'(item_ff.from_state)};
      tr_ra = {m_idx, n_ff};
      ps_we = 1'b0;
      ps_wa = {bank_ff, m_idx};
      ps_wd = sat_add(best_ff, item_ff.score);
      ps_ra = {scan_bank_ff, n_ff};
      bp_we = 1'b0;
      bp_wa = {fc_ff[FIW-1:0], m_idx};
      bp_ra = {tb_time_ff, tb_state_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (tb_active_ff) begin
               state_in = ST_EMIT;
            end else begin
               unique case (item_ff.kind)
                  KIND_LOAD: begin
                     tr_we    = 1'b1;
                     state_in = ST_IDLE;
                  end
                  KIND_EMIT: begin
                     if (fc_ok && (fc_ff != '0)) begin
                        n_in         = '0;
                        scan_arg_in  = 1'b0;
                        scan_bank_in = !bank_ff;
                        state_in     = ST_SCAN;
                     end else begin
                        state_in = ST_COMMIT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            rv_in = 1'b1;
            n_in  = n_ff + STW'(1);
            if (32'(n_ff) == 32'(ns) - 1) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (scan_arg_ff) begin
               tb_state_in = best_n_in;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // within the frame limit, store the new path score and, past frame 0, the back pointer
            if (fc_ok) begin
               ps_we = 1'b1;
               if (fc_ff == '0) begin
                  ps_wd = sat_add('0, item_ff.score);
               end else begin
                  bp_we = 1'b1;
               end
            end
            if (!item_ff.eos) begin
               fc_in    = fc_a;
               bank_in  = bank_a;
               ovf_in   = ovf_a;
               state_in = ST_IDLE;
            end else begin
               // sequence end: start the final argmax
               fc_in     = '0;
               bank_in   = 1'b0;
               ovf_in    = 1'b0;
               tb_ovf_in = ovf_a;
               if (fc_a == '0) begin
                  tb_time_in  = '0;
                  tb_state_in = '0;
                  state_in    = ST_EMIT;
               end else begin
                  tb_time_in   = FIW'(fc_a - FCW'(1));
                  n_in         = '0;
                  scan_arg_in  = 1'b1;
                  scan_bank_in = !bank_a;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff) begin
               out_load            = 1'b1;
               out_valid_in        = 1'b1;
               out_in.time_index   = TIME_BITS'(tb_time_ff);
               out_in.best_state   = STATE_BITS'(tb_state_ff);
               out_in.last         = (tb_time_ff == '0);
               out_in.overflow     = tb_ovf_ff;
               if (tb_time_ff != '0) begin
                  state_in = ST_TB_WAIT;
               end else begin
                  tb_active_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_TB_WAIT: begin
            tb_state_in  = bp_rd;
            tb_time_in   = tb_time_ff - FIW'(1);
            tb_active_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fc_ff        <= '0;
         bank_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         tb_active_ff <= 1'b0;
         tb_ovf_ff    <= 1'b0;
         rv_ff        <= 1'b0;
         scan_arg_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         bank_ff      <= bank_in;
         ovf_ff       <= ovf_in;
         tb_active_ff <= tb_active_in;
         tb_ovf_ff    <= tb_ovf_in;
         rv_ff        <= rv_in;
         scan_arg_ff  <= scan_arg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      tb_time_ff   <= tb_time_in;
      tb_state_ff  <= tb_state_in;
      n_ff         <= n_in;
      rn_ff        <= rn_in;
      best_ff      <= best_in;
      best_n_ff    <= best_n_in;
      scan_bank_ff <= scan_bank_in;
      out_ff       <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_word = out_ff;

`ifndef NO_ASSERTIONS
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !out_valid_ff)
      else $error("result register loaded while still full");

   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fc_ff) <= MAX_FRAMES)
      else $error("frame count past limit");

   a_scan_no_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !tb_active_ff)
      else $error("scan running during traceback drain");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (state_ff == ST_SCAN || state_ff == ST_SCAN_END))
      else $error("score read outside a scan");
`endif

endmodule

@@ tb/sv/viterbi_best_path_decoder_test.sv @@
// testbench for the viterbi best path decoder: scoreboard, stimulus and checks
`timescale 1ns / 1ps

// scoreboard: predicts path elements and checks the words popped from the block
class vbd_path_scoreboard;
   logic signed [15:0] trans_score [0:1023];
   logic signed [23:0] path_score [0:63];
   logic [4:0] back_ptr [0:2047];
   int unsigned frame_count;
   bit bank;
   bit ovf_seen;
   int unsigned states_used;
   bit tb_busy;
   int unsigned tb_frame;
   int unsigned tb_state;
   bit tb_ovf;
   vbd_pkg::rsp_word_type path_queue [$];
   int unsigned mismatch_count;

   function new();
      frame_count = 0;
      bank = 0;
      ovf_seen = 0;
      states_used = 32;
      tb_busy = 0;
      mismatch_count = 0;
   endfunction

   function void set_states(int unsigned value);
      if (value == 0) states_used = 1;
      else if (value > 32) states_used = 32;
      else states_used = value;
   endfunction

   // saturate a wide sum to the accumulator range
   function logic signed [23:0] clip(longint value);
      if (value > 64'sd8388607) return 24'sh7fffff;
      if (value < -64'sd8388608) return 24'sh800000;
      return value[23:0];
   endfunction

   // queue one path element and set up the next traceback step
   function void put_element(int unsigned t, int unsigned s);
      vbd_pkg::rsp_word_type w;
      w.time_index = t[5:0];
      w.best_state = s[4:0];
      w.last = (t == 0);
      w.overflow = tb_ovf;
      path_queue.insert(path_queue.size(), w);
      if (t == 0 || t >= 64) begin
         tb_busy = 0;
      end else begin
         tb_state = back_ptr[t * 32 + s];
         tb_frame = t - 1;
         tb_busy = 1;
      end
   endfunction

   // note an accepted input word
   function void note_input(vbd_pkg::req_word_type w);
      int unsigned m;
      int unsigned t;
      int unsigned best_n;
      longint best;
      longint v;
      bit prev;
      if (tb_busy) begin
         put_element(tb_frame, tb_state);
         return;
      end
      if (!w.mode) begin
         trans_score[w.to_state * 32 + w.from_state] = w.score;
         return;
      end
      m = w.to_state;
      if (m >= states_used) return;
      if (frame_count >= 64) begin
         ovf_seen = 1;
      end else begin
         prev = ~bank;
         if (frame_count == 0) begin
            path_score[bank * 32 + m] = clip(w.score);
         end else begin
            best = clip(longint'(path_score[prev * 32]) + trans_score[m * 32]);
            best_n = 0;
            for (int unsigned n = 1; n < states_used; n++) begin
               v = clip(longint'(path_score[prev * 32 + n]) + trans_score[m * 32 + n]);
               if (v > best) begin
                  best = v;
                  best_n = n;
               end
            end
            back_ptr[frame_count * 32 + m] = best_n[4:0];
            path_score[bank * 32 + m] = clip(best + w.score);
         end
         if (m == states_used - 1 || w.end_of_sequence) begin
            frame_count++;
            bank = ~bank;
         end
      end
      if (!w.end_of_sequence) return;
      t = frame_count;
      tb_ovf = ovf_seen;
      prev = ~bank;
      frame_count = 0;
      bank = 0;
      ovf_seen = 0;
      if (t == 0) begin
         put_element(0, 0);
         return;
      end
      best = path_score[prev * 32];
      best_n = 0;
      for (int unsigned n = 1; n < states_used; n++) begin
         v = path_score[prev * 32 + n];
         if (v > best) begin
            best = v;
            best_n = n;
         end
      end
      put_element(t - 1, best_n);
   endfunction

   // check one popped word against the oldest expected element
   function void check_result(vbd_pkg::rsp_word_type got);
      vbd_pkg::rsp_word_type want;
      if (path_queue.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: %p", got);
         return;
      end
      want = path_queue.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("word mismatch: expected %p actual %p", want, got);
      end
   endfunction
endclass

module viterbi_best_path_decoder_test;
   import vbd_pkg::*;

   localparam int WATCHDOG_CYCLES = 20000;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic full;
   req_word_type req_word = '0;
   logic empty;
   logic pop = 0;
   rsp_word_type rsp_word;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   vbd_path_scoreboard path_board;
   int unsigned idle_cycles;
   int unsigned states_now;

   viterbi_best_path_decoder i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   always #4 clock = ~clock;

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver with random stalls
   initial begin : result_side
      int unsigned gap;
      wait (!reset);
      forever begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         @(posedge clock);
         while (empty) @(posedge clock);
         path_board.check_result(rsp_word);
      end
   end

   // push one word, after a random gap unless no_gap is set
   task automatic send_word(req_word_type w, bit no_gap = 0);
      int unsigned gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      push <= 1;
      @(posedge clock);
      while (full) @(posedge clock);
      path_board.note_input(w);
   endtask

   task automatic build_word(output req_word_type w, input bit mode, input int unsigned to,
                             input int unsigned from, input int signed score, input bit eos);
      w.mode = mode;
      w.to_state = to[4:0];
      w.from_state = from[4:0];
      w.score = score[15:0];
      w.end_of_sequence = eos;
   endtask

   // wait until no element is pending, then for the block to settle
   task automatic drain_results();
      push <= 0;
      @(posedge clock);
      while (path_board.path_queue.size() != 0 || path_board.tb_busy) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // write the state count register in an idle window
   task automatic write_states(int unsigned value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {CSR_NUM_STATES, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      path_board.set_states(value);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      states_now = path_board.states_used;
   endtask

   // fill the whole transition table used by the current state count
   task automatic load_transitions(bit wide);
      req_word_type w;
      for (int unsigned to = 0; to < states_now; to++)
         for (int unsigned from = 0; from < states_now; from++) begin
            build_word(w, 0, to, from,
                       wide ? $urandom_range(0, 65535) : $urandom_range(0, 15) - 8,
                       1'($urandom_range(0, 1)));
            send_word(w, 1'($urandom_range(0, 1)));
         end
   endtask

   // one sequence of whole frames with optional noise
   task automatic send_sequence(int unsigned frames, bit wide, bit noisy);
      req_word_type w;
      for (int unsigned f = 0; f < frames; f++)
         for (int unsigned s = 0; s < states_now; s++) begin
            if (noisy && $urandom_range(0, 7) == 0) begin
               build_word(w, 1, $urandom_range(states_now, 31), $urandom_range(0, 31),
                          $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
               if (states_now < 32) send_word(w);
            end
            build_word(w, 1, s, $urandom_range(0, 31),
                       wide ? $urandom_range(0, 65535) : $urandom_range(0, 7),
                       f == frames - 1 && s == states_now - 1);
            send_word(w);
            if (w.end_of_sequence) begin
               // pending traceback swallows arbitrary words
               for (int unsigned k = 0; k < f; k++) begin
                  build_word(w, 1'($urandom_range(0, 1)), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 65535),
                             1'($urandom_range(0, 1)));
                  send_word(w);
               end
               return;
            end
         end
   endtask

   initial begin : stimulus
      req_word_type w;
      int unsigned sent_seqs;
      path_board = new();
      idle_cycles = 0;
      states_now = 32;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: one frame sequence, extremes of scores, ties, two states
      write_states(2);
      build_word(w, 1, 0, 31, -32768, 0);
      send_word(w);
      build_word(w, 1, 1, 31, -32768, 1);
      send_word(w);
      load_transitions(1);
      build_word(w, 0, 31, 31, 32767, 0);
      send_word(w);
      build_word(w, 1, 0, 0, 32767, 0);
      send_word(w);
      build_word(w, 1, 1, 0, -32768, 0);
      send_word(w);
      build_word(w, 1, 0, 0, 32767, 0);
      send_word(w);
      build_word(w, 1, 0, 0, 32767, 0);
      send_word(w);
      build_word(w, 1, 1, 0, 32767, 1);
      send_word(w);
      build_word(w, 1, 5, 7, 100, 0);
      send_word(w);
      drain_results();

      // one state and frame overflow
      write_states(1);
      build_word(w, 0, 0, 0, 256, 0);
      send_word(w);
      for (int i = 0; i < 66; i++) begin
         build_word(w, 1, 0, 0, $urandom_range(0, 65535), i == 65);
         send_word(w, 1);
      end
      for (int i = 0; i < 63; i++) begin
         build_word(w, 1'($urandom_range(0, 1)), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 65535),
                    1'($urandom_range(0, 1)));
         send_word(w, 1);
      end
      drain_results();

      // random: settings across the range, mostly well formed sequences
      sent_seqs = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_states(32);
            1: write_states(0);
            2: write_states(3);
            3: write_states(40);
            default: write_states($urandom_range(2, 6));
         endcase
         if (states_now <= 6 || phase == 0) begin
            // a single frame needs no transition scores
            if (states_now != 32) load_transitions(phase != 1);
            repeat (states_now == 32 ? 1 : 6) begin
               send_sequence($urandom_range(1, states_now == 32 ? 1 : 8),
                             1'($urandom_range(0, 1)), 1);
               sent_seqs++;
            end
         end
         drain_results();
      end
      if (path_board.mismatch_count == 0 && path_board.path_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ sim.f @@
design/vbd_pkg.sv
design/vbd_ram.sv
design/vbd_front.sv
design/vbd_back.sv
design/viterbi_best_path_decoder.sv
tb/sv/viterbi_best_path_decoder_test.sv
